// File: rtl/core/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, constants and arithmetic helpers for the pose point projection
// block: payload structs, configuration register codes, divider step logic.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = COEF_W + COORD_W;
    localparam int ROW_W     = 50;
    localparam int MAG_W     = ROW_W;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int ONE_SHIFT = 14;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [CFG_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [CFG_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

    localparam logic [QUO_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0 = 3'd0,
        CFG_ROT_ROW1 = 3'd1,
        CFG_ROT_ROW2 = 3'd2,
        CFG_TRANS_X  = 3'd3,
        CFG_TRANS_Y  = 3'd4,
        CFG_TRANS_Z  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] image_u;
        logic signed [COORD_W-1:0] image_v;
        logic                      zero_depth;
        logic                      saturated;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0]          rot_row0;
        logic [CFG_W-1:0]          rot_row1;
        logic [CFG_W-1:0]          rot_row2;
        logic signed [COORD_W-1:0] trans_x;
        logic signed [COORD_W-1:0] trans_y;
        logic signed [COORD_W-1:0] trans_z;
    } pose_t;

    typedef struct packed {
        logic signed [ROW_W-1:0] row0;
        logic signed [ROW_W-1:0] row1;
        logic signed [ROW_W-1:0] row2;
    } rows_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic [MAG_W-1:0]  rem;
        logic [FRAC_W-1:0] nbits;
        logic [QUO_W-1:0]  quo;
        logic              neg;
        logic              sat;
    } div_lane_t;

    typedef struct packed {
        div_lane_t        u;
        div_lane_t        v;
        logic [MAG_W-1:0] den;
        logic             zero;
    } div_stage_t;

    function automatic logic signed [PROD_W-1:0] mul_entry(
        input logic [COEF_W-1:0]          coef,
        input logic signed [COORD_W-1:0]  pt
    );
        logic signed [PROD_W-1:0] c_ext;
        logic signed [PROD_W-1:0] p_ext;
        c_ext = PROD_W'(signed'(coef));
        p_ext = PROD_W'(pt);
        return c_ext * p_ext;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [ROW_W-1:0] row);
        logic [MAG_W-1:0] raw;
        raw = MAG_W'(row);
        return row[ROW_W-1] ? (~raw + MAG_W'(1)) : raw;
    endfunction

    function automatic div_lane_t init_lane(
        input logic [MAG_W-1:0] num,
        input logic             neg,
        input logic [MAG_W-1:0] den
    );
        div_lane_t lane;
        lane.rem   = num >> FRAC_W;
        lane.nbits = num[FRAC_W-1:0];
        lane.quo   = '0;
        lane.neg   = neg;
        lane.sat   = (num >> FRAC_W) >= den;
        return lane;
    endfunction

    function automatic div_lane_t div_step(
        input div_lane_t        lane,
        input logic [MAG_W-1:0] den
    );
        div_lane_t      res;
        logic [MAG_W:0] trial;
        logic [MAG_W:0] den_ext;
        res     = lane;
        trial   = {lane.rem, lane.nbits[FRAC_W-1]};
        den_ext = {1'b0, den};
        res.nbits = lane.nbits << 1;
        if (trial >= den_ext) begin
            res.rem = MAG_W'(trial - den_ext);
            res.quo = {lane.quo[QUO_W-2:0], 1'b1};
        end else begin
            res.rem = trial[MAG_W-1:0];
            res.quo = {lane.quo[QUO_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic logic [QUO_W:0] finish_lane(input div_lane_t lane);
        logic [QUO_W-1:0] limit;
        logic [QUO_W-1:0] mag;
        logic             over;
        limit = lane.neg ? NEG_LIMIT : POS_LIMIT;
        over  = lane.sat || (lane.quo > limit);
        mag   = over ? limit : lane.quo;
        return {(lane.neg ? (~mag + QUO_W'(1)) : mag), over};
    endfunction

endpackage

// File: rtl/core/ppp_front.sv
// ----------------------------------------------------------------------------
// ppp_front
// Input side: accepts points, forms the nine rotation products, then sums
// them with the translation into the three homogeneous rows for the queue.
// ----------------------------------------------------------------------------
module ppp_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ppp_pkg::pose_t         pose,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ppp_pkg::point_t        s_payload,
    input  ppp_pkg::queue_status_t q_status,
    output logic                   q_push,
    output ppp_pkg::rows_t         q_data
);

    logic                                 adv;
    logic                                 f1_valid_reg;
    logic                                 f2_valid_reg;
    logic signed [ppp_pkg::PROD_W-1:0]    prod_reg [3][3];
    logic signed [ppp_pkg::ROW_W-1:0]     row_sum [3];
    ppp_pkg::rows_t                       rows_reg;
    ppp_pkg::rows_t                       rows_next;
    logic [ppp_pkg::CFG_W-1:0]            rot [3];
    logic signed [ppp_pkg::COORD_W-1:0]   trans [3];
    logic signed [ppp_pkg::COORD_W-1:0]   pt [3];

    assign rot[0]   = pose.rot_row0;
    assign rot[1]   = pose.rot_row1;
    assign rot[2]   = pose.rot_row2;
    assign trans[0] = pose.trans_x;
    assign trans[1] = pose.trans_y;
    assign trans[2] = pose.trans_z;
    assign pt[0]    = s_payload.point_x;
    assign pt[1]    = s_payload.point_y;
    assign pt[2]    = s_payload.point_z;

    assign adv     = !(f2_valid_reg && q_status.full);
    assign s_ready = adv;
    assign q_push  = f2_valid_reg && !q_status.full;
    assign q_data  = rows_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            row_sum[i] = ppp_pkg::ROW_W'(prod_reg[i][0])
                       + ppp_pkg::ROW_W'(prod_reg[i][1])
                       + ppp_pkg::ROW_W'(prod_reg[i][2])
                       + (ppp_pkg::ROW_W'(trans[i]) <<< ppp_pkg::ONE_SHIFT);
        end
        rows_next.row0 = row_sum[0];
        rows_next.row1 = row_sum[1];
        rows_next.row2 = row_sum[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= ppp_pkg::mul_entry(
                        rot[i][ppp_pkg::COEF_W*j +: ppp_pkg::COEF_W], pt[j]);
                end
            end
            rows_reg <= rows_next;
        end
    end

endmodule

// File: rtl/core/ppp_queue.sv
// ----------------------------------------------------------------------------
// ppp_queue
// Short first-in first-out queue of row triples between the front and the
// divider back end.
// ----------------------------------------------------------------------------
module ppp_queue #(
    parameter int DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ppp_pkg::rows_t         push_data,
    input  logic                   pop,
    output ppp_pkg::rows_t         pop_data,
    output ppp_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppp_pkg::rows_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/ppp_back.sv
// ----------------------------------------------------------------------------
// ppp_back
// Divider back end: takes row triples from the queue, splits sign and
// magnitude, runs both quotients through a one-bit-per-stage restoring
// divider pipeline and drives the output register.
// ----------------------------------------------------------------------------
module ppp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ppp_pkg::queue_status_t q_status,
    output logic                   q_pop,
    input  ppp_pkg::rows_t         q_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ppp_pkg::result_t       m_payload
);

    localparam int STEPS = ppp_pkg::QUO_W;

    logic                         adv;
    logic                         b0_valid_reg;
    logic [ppp_pkg::MAG_W-1:0]    num_u_reg;
    logic [ppp_pkg::MAG_W-1:0]    num_v_reg;
    logic [ppp_pkg::MAG_W-1:0]    den_reg;
    logic                         neg_u_reg;
    logic                         neg_v_reg;
    logic                         zero_reg;
    logic                         stg_valid_reg [STEPS+1];
    ppp_pkg::div_stage_t          stg_reg [STEPS+1];
    ppp_pkg::div_stage_t          stg_next [STEPS+1];
    logic [ppp_pkg::QUO_W:0]      fin_u;
    logic [ppp_pkg::QUO_W:0]      fin_v;
    logic                         m_valid_reg;
    ppp_pkg::result_t             result_reg;
    ppp_pkg::result_t             result_next;

    assign adv       = !(m_valid_reg && !m_ready);
    assign q_pop     = adv && !q_status.empty;
    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

    always_comb begin
        stg_next[0].u    = ppp_pkg::init_lane(num_u_reg, neg_u_reg, den_reg);
        stg_next[0].v    = ppp_pkg::init_lane(num_v_reg, neg_v_reg, den_reg);
        stg_next[0].den  = den_reg;
        stg_next[0].zero = zero_reg;
        for (int k = 1; k <= STEPS; k++) begin
            stg_next[k].u    = ppp_pkg::div_step(stg_reg[k-1].u, stg_reg[k-1].den);
            stg_next[k].v    = ppp_pkg::div_step(stg_reg[k-1].v, stg_reg[k-1].den);
            stg_next[k].den  = stg_reg[k-1].den;
            stg_next[k].zero = stg_reg[k-1].zero;
        end
    end

    always_comb begin
        fin_u = ppp_pkg::finish_lane(stg_reg[STEPS].u);
        fin_v = ppp_pkg::finish_lane(stg_reg[STEPS].v);
        if (stg_reg[STEPS].zero) begin
            result_next.image_u    = '0;
            result_next.image_v    = '0;
            result_next.zero_depth = 1'b1;
            result_next.saturated  = 1'b0;
        end else begin
            result_next.image_u    = fin_u[ppp_pkg::QUO_W:1];
            result_next.image_v    = fin_v[ppp_pkg::QUO_W:1];
            result_next.zero_depth = 1'b0;
            result_next.saturated  = fin_u[0] | fin_v[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k <= STEPS; k++) begin
                stg_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            b0_valid_reg     <= q_pop;
            stg_valid_reg[0] <= b0_valid_reg;
            for (int k = 1; k <= STEPS; k++) begin
                stg_valid_reg[k] <= stg_valid_reg[k-1];
            end
            m_valid_reg <= stg_valid_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_u_reg <= ppp_pkg::mag_of(q_data.row0);
            num_v_reg <= ppp_pkg::mag_of(q_data.row1);
            den_reg   <= ppp_pkg::mag_of(q_data.row2);
            neg_u_reg <= q_data.row0[ppp_pkg::ROW_W-1] ^ q_data.row2[ppp_pkg::ROW_W-1];
            neg_v_reg <= q_data.row1[ppp_pkg::ROW_W-1] ^ q_data.row2[ppp_pkg::ROW_W-1];
            zero_reg  <= (q_data.row2 == '0);
            for (int k = 0; k <= STEPS; k++) begin
                stg_reg[k] <= stg_next[k];
            end
            if (stg_valid_reg[STEPS]) begin
                result_reg <= result_next;
            end
        end
    end

endmodule

// File: rtl/core/pose_point_projection.sv
// ----------------------------------------------------------------------------
// pose_point_projection
// Projects a Q16.16 3D point through a rigid pose [R | t] and divides by depth.
//
// Input channel s_valid/s_ready/s_payload carries one point per transaction;
// result channel m_valid/m_ready/m_payload returns exactly one result per point,
// in order. The pose is loaded through cfg_we/cfg_index/cfg_wdata; the user
// must load it only while idle, since the block itself has no check for it.
// Throughput: one point per cycle while s_ready is high. A point passes
// through the two-stage product/sum front end, the row queue, the 32-stage
// restoring divider (one quotient bit per stage, u and v in parallel).
// Reset: rotation returns to identity, translation to zero, all pipeline
// stages and the row queue empty.
// Receiver stall: the back end holds while a result waits in the output
// register; the front end keeps taking points until the queue fills, then
// drops s_ready.
// Zero depth gives zero coordinates with zero_depth set; an out-of-range
// quotient clamps and sets saturated.
// ----------------------------------------------------------------------------
module pose_point_projection #(
    parameter int QUEUE_DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ppp_pkg::point_t                 s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ppp_pkg::result_t                m_payload
);

    ppp_pkg::pose_t         pose_reg;
    ppp_pkg::pose_t         pose_next;
    ppp_pkg::queue_status_t q_status;
    logic                   q_push;
    logic                   q_pop;
    ppp_pkg::rows_t         q_wdata;
    ppp_pkg::rows_t         q_rdata;

    always_comb begin
        pose_next = pose_reg;
        if (cfg_we) begin
            case (ppp_pkg::cfg_reg_t'(cfg_index))
                ppp_pkg::CFG_ROT_ROW0: begin
                    pose_next.rot_row0 = cfg_wdata;
                end
                ppp_pkg::CFG_ROT_ROW1: begin
                    pose_next.rot_row1 = cfg_wdata;
                end
                ppp_pkg::CFG_ROT_ROW2: begin
                    pose_next.rot_row2 = cfg_wdata;
                end
                ppp_pkg::CFG_TRANS_X: begin
                    pose_next.trans_x = cfg_wdata[ppp_pkg::COORD_W-1:0];
                end
                ppp_pkg::CFG_TRANS_Y: begin
                    pose_next.trans_y = cfg_wdata[ppp_pkg::COORD_W-1:0];
                end
                ppp_pkg::CFG_TRANS_Z: begin
                    pose_next.trans_z = cfg_wdata[ppp_pkg::COORD_W-1:0];
                end
                default: begin
                    pose_next = pose_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_reg.rot_row0 <= ppp_pkg::ROT_ROW0_RST;
            pose_reg.rot_row1 <= ppp_pkg::ROT_ROW1_RST;
            pose_reg.rot_row2 <= ppp_pkg::ROT_ROW2_RST;
            pose_reg.trans_x  <= '0;
            pose_reg.trans_y  <= '0;
            pose_reg.trans_z  <= '0;
        end else begin
            pose_reg <= pose_next;
        end
    end

    ppp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pose      (pose_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    ppp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .status    (q_status)
    );

    ppp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .q_data    (q_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_zero_depth_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.zero_depth) |->
            (m_payload.image_u == '0 && m_payload.image_v == '0 && !m_payload.saturated))
        else $error("zero depth result carries nonzero fields");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !(q_push && !q_pop && s_ready))
        else $error("row queue written while full");

    a_queue_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.empty |-> !q_pop)
        else $error("row queue read while empty");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
